// File: rtl/assert_macros.svh
// Assertion helper macros for the baud divisor RTL.
// Assumes the including module has clk and active-low synchronous rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent (consequent may carry a ## delay).
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`endif

// File: rtl/ufbd_pkg.sv
// Shared constants, fractional divider table and sideband types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ufbd_pkg;

  localparam int CLK_W    = 28;
  localparam int BAUD_W   = 22;
  localparam int WORD_W   = 24;
  localparam int FRAC_N   = 72;

  // quotient bits per divider (one pipeline stage per bit)
  localparam int QW_INT   = 24;
  localparam int QW_FRAC  = 10;
  localparam int QW_RES   = 18;

  localparam logic [9:0]  ROUND_UP_ABOVE = 10'd990;
  localparam logic [9:0]  EXACT_AT_MOST  = 10'd10;
  localparam logic [15:0] DIV16_MAX      = 16'hFFFF;
  localparam logic [CLK_W-1:0] CLK_RESET = 28'd24000000;
  // beyond this the last entry is 1000 or more away and entry 0 is kept
  localparam logic [QW_RES-1:0] RES_FAR  = 18'd2933;

  localparam logic [9:0] FRAC_TARGET [FRAC_N] = '{
    10'd0,   10'd67,  10'd71,  10'd77,  10'd83,  10'd91,  10'd100, 10'd111, 10'd125,
    10'd133, 10'd143, 10'd154, 10'd167, 10'd182, 10'd200, 10'd214, 10'd222, 10'd231,
    10'd250, 10'd267, 10'd273, 10'd286, 10'd300, 10'd308, 10'd333, 10'd357, 10'd364,
    10'd375, 10'd385, 10'd400, 10'd417, 10'd429, 10'd444, 10'd455, 10'd462, 10'd467,
    10'd500, 10'd533, 10'd538, 10'd545, 10'd556, 10'd571, 10'd583, 10'd600, 10'd615,
    10'd625, 10'd636, 10'd643, 10'd667, 10'd692, 10'd700, 10'd714, 10'd727, 10'd733,
    10'd750, 10'd769, 10'd778, 10'd786, 10'd800, 10'd818, 10'd833, 10'd846, 10'd857,
    10'd867, 10'd875, 10'd889, 10'd900, 10'd909, 10'd917, 10'd923, 10'd929, 10'd933};

  localparam logic [7:0] FRAC_CODE [FRAC_N] = '{
    8'h10, 8'hf1, 8'he1, 8'hd1, 8'hc1, 8'hb1, 8'ha1, 8'h91, 8'h81,
    8'hf2, 8'h71, 8'hd2, 8'h61, 8'hb2, 8'h51, 8'he3, 8'h92, 8'hd3,
    8'h41, 8'hf4, 8'hb3, 8'h72, 8'ha3, 8'hd4, 8'h31, 8'he5, 8'hb4,
    8'h83, 8'hd5, 8'h52, 8'hc5, 8'h73, 8'h94, 8'hb5, 8'hd6, 8'hf7,
    8'h21, 8'hf8, 8'hd7, 8'hb6, 8'h95, 8'h74, 8'hc7, 8'h53, 8'hd8,
    8'h85, 8'hb7, 8'he9, 8'h32, 8'hd9, 8'ha7, 8'h75, 8'hb8, 8'hfb,
    8'h43, 8'hda, 8'h97, 8'heb, 8'h54, 8'hb9, 8'h65, 8'hdb, 8'h76,
    8'hfd, 8'h87, 8'h98, 8'ha9, 8'hba, 8'hcb, 8'hdc, 8'hed, 8'hfe};

  // twice the midpoint between neighbor targets (targets offset by 1000)
  function automatic logic [11:0] mid_sum(input int i);
    mid_sum = 12'd2000 + 12'(FRAC_TARGET[i]) + 12'(FRAC_TARGET[i+1]);
  endfunction

  typedef struct packed {
    logic [QW_INT-1:0] ipart;
    logic [QW_INT-1:0] dl;
    logic [BAUD_W-1:0] baud;
    logic              zero;
  } frac_side_t;

  typedef struct packed {
    logic [QW_INT-1:0]  ipart;
    logic [QW_FRAC-1:0] frac;
    logic [15:0]        dls;
    logic               dl_zero;
    logic               dl_sat;
    logic               zero;
  } res_side_t;

endpackage
`default_nettype wire

// File: rtl/ufbd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Requires num >> QW < den. Uses no package.
`timescale 1ns / 1ps
`default_nettype none
module ufbd_div #(
  parameter int NW = 28,
  parameter int DW = 26,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [DW-1:0]      out_rem,
  output logic [SW-1:0]      out_side
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] lo_r   [QW];
  logic [QW-1:0] q_r    [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0] rem_in, den_in, rem_nxt;
    logic [QW-1:0] lo_in, q_in;
    logic [SW-1:0] side_in;
    logic          v_in, qbit;
    logic [DW:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in  = DW'(in_num >> QW);
      assign lo_in   = in_num[QW-1:0];
      assign q_in    = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign lo_in   = lo_r[s-1];
      assign q_in    = q_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
      assign v_in    = vld_r[s-1];
    end

    always_comb begin
      trial   = {rem_in, lo_in[QW-1]};
      qbit    = (trial >= {1'b0, den_in});
      rem_nxt = qbit ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      lo_r[s]   <= {lo_in[QW-2:0], 1'b0};
      q_r[s]    <= {q_in[QW-2:0], qbit};
      den_r[s]  <= den_in;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = q_r[QW-1];
  assign out_rem   = rem_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
`default_nettype wire

// File: rtl/uart_fractional_baud_divisor.sv
// UART fractional baud divisor, top level.
// Depends on ufbd_pkg, ufbd_div and assert_macros.svh.
//
// Usage:
//   cfg_we/cfg_wdata write the peripheral clock in Hz (reset 24000000).
//   Write it only while no request is in flight.
//   A request beat is taken when start is high; busy is always low, so a
//   new baud rate can enter on every cycle.
//   Each request yields one result beat: out_valid is high for one cycle
//   with out_divisor_word and out_invalid. Results come back in order.
//   Pipeline stages from the accepting edge to the out_valid cycle:
//   24 stages for the integer and latch dividers (run side by side),
//   10 for the fraction, 1 multiply, 18 for the residual ratio, 1 table
//   compare and 1 output register. Throughput is one result per cycle.
//   The receiver cannot stall; results are not held.
//   Reset clears all valid bits, so nothing in flight survives it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module uart_fractional_baud_divisor
  import ufbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CLK_W-1:0]  cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [BAUD_W-1:0] in_baud_rate,
  output logic                   out_valid,
  output logic [WORD_W-1:0]      out_divisor_word,
  output logic                   out_invalid
);

  localparam int LATENCY = QW_INT + QW_FRAC + QW_RES + 3;
  localparam int DEN16_W = BAUD_W + 4;
  localparam int DEN24_W = BAUD_W + 5;
  localparam int RES_DW  = DEN16_W + 16;
  localparam int MILLI_W = CLK_W + 10;

  logic [CLK_W-1:0] clk_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  logic               in_go;
  logic [DEN16_W-1:0] den16_in;
  logic [DEN24_W-1:0] den24_in;
  logic [MILLI_W-1:0] clk_milli;

  assign in_go     = start && !busy;
  assign den16_in  = {in_baud_rate, 4'b0};
  assign den24_in  = DEN24_W'({in_baud_rate, 4'b0}) + DEN24_W'({in_baud_rate, 3'b0});
  assign clk_milli = MILLI_W'(clk_hz_r) * MILLI_W'(1000);

  // integer part clk/(16*baud) and latch divisor clk/(24*baud)
  logic               a_v, l_v;
  logic [QW_INT-1:0]  a_quo, l_quo;
  logic [DEN16_W-1:0] a_rem;
  logic [DEN24_W-1:0] l_rem;
  logic [BAUD_W-1:0]  a_baud;
  logic               l_zero;

  ufbd_div #(.NW(CLK_W), .DW(DEN16_W), .QW(QW_INT), .SW(BAUD_W)) u_div_int (
    .clk(clk), .rst_n(rst_n), .in_valid(in_go), .in_num(clk_hz_r),
    .in_den(den16_in), .in_side(in_baud_rate),
    .out_valid(a_v), .out_quo(a_quo), .out_rem(a_rem), .out_side(a_baud)
  );

  ufbd_div #(.NW(CLK_W), .DW(DEN24_W), .QW(QW_INT), .SW(1)) u_div_dl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_go), .in_num(clk_hz_r),
    .in_den(den24_in), .in_side(in_baud_rate == '0),
    .out_valid(l_v), .out_quo(l_quo), .out_rem(l_rem), .out_side(l_zero)
  );

  // fraction in thousandths: remainder*1000 / (16*baud)
  frac_side_t         f_in_side, f_side;
  logic               f_v;
  logic [QW_FRAC-1:0] f_quo;
  logic [DEN16_W-1:0] f_rem;

  assign f_in_side = '{ipart: a_quo, dl: l_quo, baud: a_baud, zero: l_zero};

  ufbd_div #(.NW(DEN16_W + QW_FRAC), .DW(DEN16_W), .QW(QW_FRAC),
             .SW($bits(frac_side_t))) u_div_frac (
    .clk(clk), .rst_n(rst_n), .in_valid(a_v),
    .in_num((DEN16_W + QW_FRAC)'(a_rem) * (DEN16_W + QW_FRAC)'(1000)),
    .in_den({a_baud, 4'b0}), .in_side(f_in_side),
    .out_valid(f_v), .out_quo(f_quo), .out_rem(f_rem), .out_side(f_side)
  );

  // saturate latch divisor and form 16*baud*dl
  res_side_t         m_nxt, m_r;
  logic [RES_DW-1:0] mden_r;
  logic              m_v_r;
  logic [15:0]       dls;
  logic              dl_sat;

  always_comb begin
    dl_sat = (f_side.dl > QW_INT'(DIV16_MAX));
    dls    = dl_sat ? DIV16_MAX : f_side.dl[15:0];
    m_nxt  = '{ipart: f_side.ipart, frac: f_quo, dls: dls,
               dl_zero: (f_side.dl == '0), dl_sat: dl_sat, zero: f_side.zero};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    mden_r <= RES_DW'({f_side.baud, 4'b0}) * RES_DW'(dls);
  end

  // residual ratio in thousandths
  res_side_t         r_side;
  logic              r_v;
  logic [QW_RES-1:0] r_quo;
  logic [RES_DW-1:0] r_rem;

  ufbd_div #(.NW(MILLI_W), .DW(RES_DW), .QW(QW_RES),
             .SW($bits(res_side_t))) u_div_res (
    .clk(clk), .rst_n(rst_n), .in_valid(m_v_r), .in_num(clk_milli),
    .in_den(mden_r), .in_side(m_r),
    .out_valid(r_v), .out_quo(r_quo), .out_rem(r_rem), .out_side(r_side)
  );

  // thermometer of midpoints crossed; ties stay on the lower entry
  logic [FRAC_N-2:0] th_nxt, th_r;
  logic              far_r, t_v_r;
  res_side_t         t_r;

  always_comb begin
    for (int i = 0; i < FRAC_N - 1; i++) begin
      th_nxt[i] = ({r_quo, 1'b0} > (QW_RES + 1)'(mid_sum(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else begin
      t_v_r <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    th_r  <= th_nxt;
    far_r <= (r_quo >= RES_FAR);
    t_r   <= r_side;
  end

  // final selection
  logic [6:0]        idx;
  logic [7:0]        code;
  logic [QW_INT:0]   ipart_up;
  logic [15:0]       int_sat;
  logic              int_bad;
  logic              frac_path;
  logic [WORD_W-1:0] word_nxt;
  logic              bad_nxt;

  always_comb begin
    idx = '0;
    for (int i = 0; i < FRAC_N - 1; i++) begin
      if (th_r[i]) begin
        idx = 7'(i + 1);
      end
    end
    code      = far_r ? FRAC_CODE[0] : FRAC_CODE[idx];
    frac_path = (t_r.frac > EXACT_AT_MOST) && (t_r.frac <= ROUND_UP_ABOVE);
    ipart_up  = {1'b0, t_r.ipart} + (QW_INT + 1)'(t_r.frac > ROUND_UP_ABOVE);
    if (!frac_path || t_r.dl_zero) begin
      // rounding only happens off the fractional path
      int_sat = (ipart_up > (QW_INT + 1)'(DIV16_MAX)) ? DIV16_MAX : ipart_up[15:0];
      int_bad = (ipart_up == '0) || (ipart_up > (QW_INT + 1)'(DIV16_MAX));
    end else begin
      int_sat = '0;
      int_bad = 1'b0;
    end
    if (t_r.zero) begin
      word_nxt = '0;
      bad_nxt  = 1'b1;
    end else if (frac_path && !t_r.dl_zero) begin
      word_nxt = {code, t_r.dls};
      bad_nxt  = t_r.dl_sat;
    end else begin
      word_nxt = WORD_W'(int_sat);
      bad_nxt  = int_bad || (frac_path && t_r.dl_zero);
    end
  end

  logic              out_v_r;
  logic [WORD_W-1:0] word_r;
  logic              bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_divisor_word = word_r;
  assign out_invalid      = bad_r;

  `ASSERT_ALWAYS(a_div_align, a_v == l_v, "integer and latch dividers out of step")
  `ASSERT_IMPLIES(a_latency, in_go, ##LATENCY out_valid, "result beat missing at latency")
  `ASSERT_IMPLIES(a_valid_nonzero, out_valid && !out_invalid, out_divisor_word[15:0] != 16'd0, "valid result with zero divisor")

endmodule
`default_nettype wire

// File: sim/uart_fractional_baud_divisor_test.sv
// Testbench for uart_fractional_baud_divisor: directed table, then random baud requests.
// Depends on ufbd_pkg (widths, table constants) and the RTL top level.
`timescale 1ns / 1ps
module uart_fractional_baud_divisor_test;
  import ufbd_pkg::*;

  localparam int LATENCY = 55;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1250;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CLK_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  logic [BAUD_W-1:0] in_baud_rate;
  logic              out_valid;
  logic [WORD_W-1:0] out_divisor_word;
  logic              out_invalid;

  uart_fractional_baud_divisor dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_baud_rate(in_baud_rate),
    .out_valid(out_valid), .out_divisor_word(out_divisor_word),
    .out_invalid(out_invalid)
  );

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              invalid;
  } divisor_t;

  typedef struct {
    logic [CLK_W-1:0]  pclk;
    logic [BAUD_W-1:0] baud;
    bit                known;
    divisor_t          want;
  } stim_row_t;

  divisor_t        pending_divisors[$];
  logic [CLK_W-1:0] pclk_hz;
  int              errors;
  int              idle_cycles;
  int              send_gap_pct;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [7:0] nearest_frac_code(input longint unsigned resid);
    longint unsigned best, gap, tgt;
    int pick;
    best = 1000;
    pick = 0;
    for (int i = 0; i < FRAC_N; i++) begin
      tgt = 1000 + FRAC_TARGET[i];
      gap = resid >= tgt ? resid - tgt : tgt - resid;
      if (gap < best) begin
        best = gap;
        pick = i;
      end
    end
    return FRAC_CODE[pick];
  endfunction

  function automatic divisor_t compute_divisor(input logic [CLK_W-1:0] pclk,
                                               input logic [BAUD_W-1:0] baud);
    longint unsigned c, b, ratio, ipart, frac, dl, resid;
    divisor_t d;
    c = pclk;
    b = baud;
    d = '0;
    if (b == 0) begin
      d.invalid = 1'b1;
      return d;
    end
    ratio = (c * 1000) / (16 * b);
    ipart = ratio / 1000;
    frac = ratio % 1000;
    if (frac > 990) ipart++;
    dl = 0;
    if (frac > 10 && frac <= 990) begin
      dl = c / (24 * b);
      if (dl == 0) d.invalid = 1'b1;
    end
    if (dl == 0) begin
      if (ipart == 0) d.invalid = 1'b1;
      if (ipart > 64'hFFFF) begin
        ipart = 64'hFFFF;
        d.invalid = 1'b1;
      end
      d.word = ipart[WORD_W-1:0];
    end else begin
      if (dl > 64'hFFFF) begin
        dl = 64'hFFFF;
        d.invalid = 1'b1;
      end
      resid = (c * 1000) / (16 * b * dl);
      d.word = {nearest_frac_code(resid), dl[15:0]};
    end
    return d;
  endfunction

  // result checker; watchdog counts cycles with no beat either way
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_divisors.size() == 0) begin
          $display("%0t unexpected result: actual word %h invalid %b",
                   $time, out_divisor_word, out_invalid);
          errors++;
        end else begin
          divisor_t e;
          e = pending_divisors.pop_front();
          if (e.word !== out_divisor_word) begin
            $display("%0t divisor_word: expected %h actual %h", $time, e.word,
                     out_divisor_word);
            errors++;
          end
          if (e.invalid !== out_invalid) begin
            $display("%0t invalid: expected %b actual %b", $time, e.invalid,
                     out_invalid);
            errors++;
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one request beat; holds start across back-to-back beats
  task automatic send_baud(input logic [BAUD_W-1:0] baud, input bit known,
                           input divisor_t want);
    divisor_t d;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_baud_rate <= baud;
    @(posedge clk);
    while (busy) @(posedge clk);
    d = compute_divisor(pclk_hz, baud);
    if (known && d !== want) begin
      $display("%0t table row baud %0d: expected %h/%b predicted %h/%b", $time, baud,
               want.word, want.invalid, d.word, d.invalid);
      errors++;
    end
    pending_divisors.push_back(known ? want : d);
    @(negedge clk);
  endtask

  // called at a falling edge; start drops before the next rising edge
  task automatic drain_and_set_clock(input logic [CLK_W-1:0] hz);
    start <= 1'b0;
    while (pending_divisors.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    pclk_hz = hz;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BAUD_W-1:0] random_baud();
    int r;
    r = $urandom_range(99);
    if (r < 40) return BAUD_W'($urandom_range(300, 921600));
    if (r < 60) return BAUD_W'($urandom_range(1, 2000));
    if (r < 80) return BAUD_W'($urandom_range(4000000));
    return BAUD_W'($urandom);
  endfunction

  stim_row_t directed[] = '{
    '{CLK_RESET, 22'd0,       1'b1, '{24'h0, 1'b1}},
    '{CLK_RESET, 22'd3,       1'b1, '{24'hFFFF, 1'b1}},
    '{CLK_RESET, 22'h3FFFFF,  1'b1, '{24'h0, 1'b1}},
    '{CLK_RESET, 22'd1500000, 1'b1, '{24'd1, 1'b0}},
    '{CLK_RESET, 22'd115200,  1'b0, '{24'h0, 1'b0}},
    '{CLK_RESET, 22'd9600,    1'b0, '{24'h0, 1'b0}},
    '{CLK_RESET, 22'd1,       1'b0, '{24'h0, 1'b0}},
    '{CLK_RESET, 22'd1000000, 1'b0, '{24'h0, 1'b0}},
    '{CLK_RESET, 22'd2000000, 1'b0, '{24'h0, 1'b0}},
    '{28'd1000,  22'd0,       1'b1, '{24'h0, 1'b1}},
    '{28'd1000,  22'd1,       1'b0, '{24'h0, 1'b0}},
    '{28'd1000,  22'd50,      1'b0, '{24'h0, 1'b0}},
    '{28'd1000,  22'd100,     1'b0, '{24'h0, 1'b0}},
    '{28'd1000,  22'd4000000, 1'b1, '{24'h0, 1'b1}},
    '{28'hFFFFFFF, 22'd1,     1'b0, '{24'h0, 1'b0}},
    '{28'hFFFFFFF, 22'd200,   1'b0, '{24'h0, 1'b0}},
    '{28'hFFFFFFF, 22'h3FFFFF, 1'b0, '{24'h0, 1'b0}},
    '{28'd200000000, 22'd115200, 1'b0, '{24'h0, 1'b0}},
    '{28'd200000000, 22'd3000000, 1'b0, '{24'h0, 1'b0}},
    '{28'd200000000, 22'd190, 1'b0, '{24'h0, 1'b0}}
  };

  initial begin
    logic [CLK_W-1:0] clocks[6];
    errors = 0;
    idle_cycles = 0;
    send_gap_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    in_baud_rate = '0;
    pclk_hz = CLK_RESET;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].pclk != pclk_hz) drain_and_set_clock(directed[i].pclk);
      send_baud(directed[i].baud, directed[i].known, directed[i].want);
    end

    clocks = '{28'd1000, 28'd200000000, 28'hFFFFFFF, CLK_RESET, 28'd14745600, 28'd0};
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = phase == 0 ? 17 : (phase == 1 ? 87 : 0);
      for (int k = 0; k < RANDOM_BEATS / 3; k++) begin
        if (k % 70 == 0) begin
          logic [CLK_W-1:0] hz;
          hz = clocks[$urandom_range(5)];
          if (hz == 0) hz = CLK_W'($urandom_range(1000, 200000000));
          if ($urandom_range(3) == 0) hz = CLK_W'($urandom);
          drain_and_set_clock(hz);
        end
        send_baud(random_baud(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_divisors.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: uart_fractional_baud_divisor.f
+incdir+rtl
rtl/ufbd_pkg.sv
rtl/ufbd_div.sv
rtl/uart_fractional_baud_divisor.sv
sim/uart_fractional_baud_divisor_test.sv
